// ===== hw/rtl/fit_pkg.sv =====
// ----------------------------------------------------------------------------
// fit_pkg
// Shared types and codes for the frame interval table.
// ----------------------------------------------------------------------------
package fit_pkg;

    // Command codes carried on s_tuser
    typedef enum logic [1:0] {
        FIT_CMD_ADD  = 2'd0,
        FIT_CMD_DEL  = 2'd1,
        FIT_CMD_FIND = 2'd2
    } fit_cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        FIT_ST_OK       = 3'd0,
        FIT_ST_RANGE    = 3'd1,
        FIT_ST_OVERLAP  = 3'd2,
        FIT_ST_FULL     = 3'd3,
        FIT_ST_NOTFOUND = 3'd4
    } fit_status_t;

    localparam int unsigned FIT_STATUS_W = 3;
    localparam int unsigned FIT_CMD_W    = 2;

    // Control states, one-hot
    typedef enum logic [1:0] {
        FIT_IDLE   = 2'b01,
        FIT_SEARCH = 2'b10
    } fit_state_t;

endpackage

// ===== hw/rtl/fit_first_set.sv =====
// ----------------------------------------------------------------------------
// fit_first_set
// Priority encoder: index of the lowest set bit of a vector.
// ----------------------------------------------------------------------------
module fit_first_set #(
    parameter int unsigned N  = 64,
    parameter int unsigned IW = 6
) (
    input  logic [N-1:0]  vec,
    output logic          found,
    output logic [IW-1:0] idx
);

    assign found = |vec;

    // Scan from the top so the lowest set bit wins
    always_comb begin
        idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IW'(i);
            end
        end
    end

endmodule

// ===== hw/rtl/frame_interval_table.sv =====
// ----------------------------------------------------------------------------
// frame_interval_table
// Table of non-overlapping inclusive frame ranges with replacement frames:
// add with range and overlap checks, delete by start frame, find by frame.
// ----------------------------------------------------------------------------
// One result beat appears on m_tvalid in the cycle after the command beat is
//   accepted, but for an enclosing add; one command per cycle if not stalled.
// An add whose range has no stored range containing its ends but encloses
//   stored ranges holds its result while the lowest enclosed start is found
//   by a search over one table entry per cycle through the read port.
// Reset (aresetn low, synchronous) clears all valid bits, frame_count and
//   the handshake state at once; entry payloads are not cleared.
// ----------------------------------------------------------------------------
module frame_interval_table
    import fit_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned FRAME_BITS    = 24
) (
    input  logic aclk,
    input  logic aresetn,

    // Configuration write: frame_count
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [FRAME_BITS:0]     cfg_data,

    // Command stream
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // tdata, lowest bit up: frame_a, frame_b, replace_frame, zero fill
    input  logic [((3*FRAME_BITS+7)/8)*8-1:0]           s_tdata,
    // tuser: cmd
    input  logic [FIT_CMD_W-1:0]                        s_tuser,

    // Result stream
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // tdata, lowest bit up: status, hit_first, hit_last, hit_replace, zero fill
    output logic [((FIT_STATUS_W+3*FRAME_BITS+7)/8)*8-1:0] m_tdata,
    // tuser: hit
    output logic                                        m_tuser
);

    localparam int unsigned F        = FRAME_BITS;
    localparam int unsigned IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned M_DATA_W = ((FIT_STATUS_W + 3*FRAME_BITS + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Table storage: valid bits reset, payload only written on add
    // ------------------------------------------------------------------
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [F-1:0]             first_reg   [TABLE_ENTRIES];
    logic [F-1:0]             last_reg    [TABLE_ENTRIES];
    logic [F-1:0]             replace_reg [TABLE_ENTRIES];

    logic [F:0]               frame_count_reg;

    // Control and output registers
    fit_state_t               state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] mask_reg, mask_next;
    logic                     best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [F-1:0]             best_first_reg, best_first_next;

    logic                     m_valid_reg, m_valid_next;
    fit_status_t              status_reg, status_next;
    logic                     hit_reg, hit_next;
    logic [F-1:0]             hit_first_reg, hit_first_next;
    logic [F-1:0]             hit_last_reg, hit_last_next;
    logic [F-1:0]             hit_replace_reg, hit_replace_next;

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [F-1:0] in_a, in_b, in_r;
    assign in_a = s_tdata[F-1:0];
    assign in_b = s_tdata[2*F-1:F];
    assign in_r = s_tdata[3*F-1:2*F];

    logic s_accept, out_free;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == FIT_IDLE) && out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Parallel compare against every entry
    // ------------------------------------------------------------------
    logic [TABLE_ENTRIES-1:0] has_a, has_b, enclosed, start_eq, free_vec;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            has_a[i]    = valid_reg[i] && (first_reg[i] <= in_a) && (in_a <= last_reg[i]);
            has_b[i]    = valid_reg[i] && (first_reg[i] <= in_b) && (in_b <= last_reg[i]);
            enclosed[i] = valid_reg[i] && (first_reg[i] > in_a) && (first_reg[i] <= in_b);
            start_eq[i] = valid_reg[i] && (first_reg[i] == in_a);
            free_vec[i] = !valid_reg[i];
        end
    end

    logic             a_found, b_found, del_found, free_found, lo_found;
    logic [IDX_W-1:0] a_idx, b_idx, del_idx, free_idx, lo_idx;

    fit_first_set #(.N(TABLE_ENTRIES), .IW(IDX_W)) u_has_a (
        .vec(has_a), .found(a_found), .idx(a_idx)
    );
    fit_first_set #(.N(TABLE_ENTRIES), .IW(IDX_W)) u_has_b (
        .vec(has_b), .found(b_found), .idx(b_idx)
    );
    fit_first_set #(.N(TABLE_ENTRIES), .IW(IDX_W)) u_del (
        .vec(start_eq), .found(del_found), .idx(del_idx)
    );
    fit_first_set #(.N(TABLE_ENTRIES), .IW(IDX_W)) u_free (
        .vec(free_vec), .found(free_found), .idx(free_idx)
    );
    // Next enclosed candidate during the minimum-start search
    fit_first_set #(.N(TABLE_ENTRIES), .IW(IDX_W)) u_search (
        .vec(mask_reg), .found(lo_found), .idx(lo_idx)
    );

    // Range check for an add: every value below frame_count, first <= last
    logic add_bad;
    assign add_bad = ({1'b0, in_a} >= frame_count_reg) || ({1'b0, in_b} >= frame_count_reg)
                  || ({1'b0, in_r} >= frame_count_reg) || (in_a > in_b);

    // ------------------------------------------------------------------
    // Single table read port, shared by result readout and search
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] rd_idx;
    logic [F-1:0]     rd_first, rd_last, rd_replace;

    assign rd_first   = first_reg[rd_idx];
    assign rd_last    = last_reg[rd_idx];
    assign rd_replace = replace_reg[rd_idx];

    // ------------------------------------------------------------------
    // Command decode and next-state logic
    // ------------------------------------------------------------------
    logic do_write, do_clear, load_out;

    always_comb begin
        state_next       = state_reg;
        mask_next        = mask_reg;
        best_valid_next  = best_valid_reg;
        best_idx_next    = best_idx_reg;
        best_first_next  = best_first_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        status_next      = status_reg;
        hit_next         = hit_reg;
        rd_idx           = a_idx;
        do_write         = 1'b0;
        do_clear         = 1'b0;
        load_out         = 1'b0;

        unique case (state_reg)
            FIT_IDLE: begin
                if (s_accept) begin
                    load_out = 1'b1;
                    hit_next = 1'b0;
                    unique case (s_tuser)
                        FIT_CMD_ADD: begin
                            if (add_bad) begin
                                status_next = FIT_ST_RANGE;
                            end else if (a_found) begin
                                status_next = FIT_ST_OVERLAP;
                                hit_next    = 1'b1;
                            end else if (b_found) begin
                                status_next = FIT_ST_OVERLAP;
                                hit_next    = 1'b1;
                                rd_idx      = b_idx;
                            end else if (|enclosed) begin
                                // Hold the result until the lowest start is known
                                load_out        = 1'b0;
                                state_next      = FIT_SEARCH;
                                mask_next       = enclosed;
                                best_valid_next = 1'b0;
                            end else if (!free_found) begin
                                status_next = FIT_ST_FULL;
                            end else begin
                                status_next = FIT_ST_OK;
                                do_write    = 1'b1;
                            end
                        end
                        FIT_CMD_DEL: begin
                            if (del_found) begin
                                status_next = FIT_ST_OK;
                                do_clear    = 1'b1;
                            end else begin
                                status_next = FIT_ST_NOTFOUND;
                            end
                        end
                        FIT_CMD_FIND: begin
                            status_next = a_found ? FIT_ST_OK : FIT_ST_NOTFOUND;
                            hit_next    = a_found;
                        end
                        default: begin
                            status_next = FIT_ST_RANGE;
                        end
                    endcase
                end
            end
            FIT_SEARCH: begin
                if (lo_found) begin
                    // Compare one candidate per cycle, then drop it
                    rd_idx    = lo_idx;
                    mask_next = mask_reg & (mask_reg - TABLE_ENTRIES'(1));
                    if (!best_valid_reg || (rd_first < best_first_reg)) begin
                        best_valid_next = 1'b1;
                        best_idx_next   = lo_idx;
                        best_first_next = rd_first;
                    end
                end else begin
                    rd_idx = best_idx_reg;
                    if (out_free) begin
                        load_out    = 1'b1;
                        status_next = FIT_ST_OVERLAP;
                        hit_next    = 1'b1;
                        state_next  = FIT_IDLE;
                    end
                end
            end
            default: begin
                state_next = FIT_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    // Reported entry fields read as zero without a hit
    assign hit_first_next   = rd_first & {F{hit_next}};
    assign hit_last_next    = rd_last & {F{hit_next}};
    assign hit_replace_next = rd_replace & {F{hit_next}};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= FIT_IDLE;
            m_valid_reg     <= 1'b0;
            valid_reg       <= '0;
            frame_count_reg <= '0;
            best_valid_reg  <= 1'b0;
            mask_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            best_valid_reg <= best_valid_next;
            mask_reg       <= mask_next;
            if (cfg_valid && cfg_ready) begin
                frame_count_reg <= cfg_data;
            end
            if (do_write) begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (do_clear) begin
                valid_reg[del_idx] <= 1'b0;
            end
        end
    end

    // Payload: entry data and result fields need no reset
    always_ff @(posedge aclk) begin
        best_idx_reg   <= best_idx_next;
        best_first_reg <= best_first_next;
        if (do_write) begin
            first_reg[free_idx]   <= in_a;
            last_reg[free_idx]    <= in_b;
            replace_reg[free_idx] <= in_r;
        end
        if (load_out) begin
            status_reg      <= status_next;
            hit_reg         <= hit_next;
            hit_first_reg   <= hit_first_next;
            hit_last_reg    <= hit_last_next;
            hit_replace_reg <= hit_replace_next;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = M_DATA_W'({hit_replace_reg, hit_last_reg, hit_first_reg, status_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No command enters while the enclosed-range search runs
    a_search_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FIT_SEARCH) |-> !s_tready)
        else $error("command accepted during search");

    // Search candidates only ever drop out
    a_mask_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FIT_SEARCH && $past(state_reg == FIT_SEARCH))
            |-> ((mask_reg & ~$past(mask_reg)) == '0))
        else $error("search candidate set grew");

    // A stored add fills exactly one more slot
    a_add_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("add did not fill one slot");

    // A reported entry comes only with ok or overlap status
    a_hit_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && hit_reg) |-> (status_reg == FIT_ST_OK || status_reg == FIT_ST_OVERLAP))
        else $error("hit with wrong status");

endmodule

// ===== tb/sv/fit_checker.sv =====
// ----------------------------------------------------------------------------
// fit_checker
// Watches the configuration, command and result channels of the frame
// interval table, keeps its own copy of the table to predict each result,
// and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module fit_checker
    import fit_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned FRAME_BITS    = 24
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           cfg_valid,
    input  logic                                           cfg_ready,
    input  logic [FRAME_BITS:0]                            cfg_data,
    input  logic                                           s_tvalid,
    input  logic                                           s_tready,
    input  logic [((3*FRAME_BITS+7)/8)*8-1:0]              s_tdata,
    input  logic [FIT_CMD_W-1:0]                           s_tuser,
    input  logic                                           m_tvalid,
    input  logic                                           m_tready,
    input  logic [((FIT_STATUS_W+3*FRAME_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                                           m_tuser,
    output int unsigned                                    fail_count,
    output int unsigned                                    pending,
    output int unsigned                                    results_seen,
    output int unsigned                                    hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef struct packed {
        logic [FIT_STATUS_W-1:0] status;
        logic                    hit;
        frame_t                  first;
        frame_t                  last;
        frame_t                  repl;
    } span_result_t;

    logic                slot_used  [TABLE_ENTRIES];
    frame_t              slot_first [TABLE_ENTRIES];
    frame_t              slot_last  [TABLE_ENTRIES];
    frame_t              slot_repl  [TABLE_ENTRIES];
    logic [FRAME_BITS:0] frame_limit;
    span_result_t        expected_q [$];
    int unsigned         mismatches;
    int unsigned         result_total;
    int unsigned         hit_total;

    function automatic int containing_slot(frame_t f);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && slot_first[i] <= f && f <= slot_last[i])
                return i;
        return -1;
    endfunction

    function automatic span_result_t report(fit_status_t st, int idx);
        span_result_t res;
        res = '0;
        res.status = st;
        if (idx >= 0) begin
            res.hit   = 1'b1;
            res.first = slot_first[idx];
            res.last  = slot_last[idx];
            res.repl  = slot_repl[idx];
        end
        return res;
    endfunction

    // Apply one command to the table copy and return the result it gives.
    function automatic span_result_t apply_command(logic [FIT_CMD_W-1:0] cmd,
                                                   frame_t a, frame_t b, frame_t r);
        int idx;
        int free_slot;
        idx = -1;
        free_slot = -1;
        case (cmd)
            FIT_CMD_ADD: begin
                if ({1'b0, a} >= frame_limit || {1'b0, b} >= frame_limit ||
                    {1'b0, r} >= frame_limit || a > b)
                    return report(FIT_ST_RANGE, -1);
                idx = containing_slot(a);
                if (idx < 0)
                    idx = containing_slot(b);
                // enclosed ranges: report the lowest start
                if (idx < 0)
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (slot_used[i] && slot_first[i] > a && slot_first[i] <= b &&
                            (idx < 0 || slot_first[i] < slot_first[idx]))
                            idx = i;
                if (idx >= 0)
                    return report(FIT_ST_OVERLAP, idx);
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                    if (!slot_used[i])
                        free_slot = i;
                if (free_slot < 0)
                    return report(FIT_ST_FULL, -1);
                slot_used[free_slot]  = 1'b1;
                slot_first[free_slot] = a;
                slot_last[free_slot]  = b;
                slot_repl[free_slot]  = r;
                return report(FIT_ST_OK, -1);
            end
            FIT_CMD_DEL: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (slot_used[i] && slot_first[i] == a) begin
                        slot_used[i] = 1'b0;
                        return report(FIT_ST_OK, -1);
                    end
                return report(FIT_ST_NOTFOUND, -1);
            end
            FIT_CMD_FIND: begin
                idx = containing_slot(a);
                return report(idx >= 0 ? FIT_ST_OK : FIT_ST_NOTFOUND, idx);
            end
            default: return report(FIT_ST_RANGE, -1);
        endcase
    endfunction

    always @(posedge aclk) begin
        span_result_t want;
        span_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                slot_used[i] = 1'b0;
            frame_limit = '0;
            expected_q.delete();
        end else begin
            // results first: a result never belongs to a command of the same beat
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[FIT_STATUS_W-1:0];
                got.hit    = m_tuser;
                got.first  = m_tdata[FIT_STATUS_W +: FRAME_BITS];
                got.last   = m_tdata[FIT_STATUS_W+FRAME_BITS +: FRAME_BITS];
                got.repl   = m_tdata[FIT_STATUS_W+2*FRAME_BITS +: FRAME_BITS];
                result_total++;
                if (got.hit)
                    hit_total++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d hit %0b", got.status,
                                 got.hit);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d mismatch: expected status %0d hit %0b ",
                                      "[%0d..%0d] repl %0d, got status %0d hit %0b ",
                                      "[%0d..%0d] repl %0d"},
                                     result_total, want.status, want.hit, want.first,
                                     want.last, want.repl, got.status, got.hit, got.first,
                                     got.last, got.repl);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                frame_limit = cfg_data;
            if (s_tvalid && s_tready)
                expected_q = {expected_q,
                              apply_command(s_tuser, s_tdata[0 +: FRAME_BITS],
                                            s_tdata[FRAME_BITS +: FRAME_BITS],
                                            s_tdata[2*FRAME_BITS +: FRAME_BITS])};
        end
        fail_count   <= mismatches;
        pending      <= expected_q.size();
        results_seen <= result_total;
        hits_seen    <= hit_total;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the frame interval table with a directed sequence and randomized
// add, delete, find and unknown-command traffic under several frame_count
// settings, with random gaps and back-pressure; fit_checker predicts and checks results.
// ----------------------------------------------------------------------------
module tb_top
    import fit_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_ENTRIES = 64;
    localparam int unsigned FRAME_BITS    = 24;
    localparam int unsigned S_W           = ((3*FRAME_BITS+7)/8)*8;
    localparam int unsigned M_W           = ((FIT_STATUS_W+3*FRAME_BITS+7)/8)*8;

    // cmd 3 is not a legal command; the block must answer it as out of range
    localparam logic [FIT_CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [FRAME_BITS:0]   FULL_SPAN  = 25'd16777216;
    localparam logic [FRAME_BITS-1:0] FRAME_MAX  = 24'hFFFFFF;
    localparam int unsigned IDLE_PCT      = 20;
    localparam int unsigned SETTLE_CYCLES = 4;
    // longest add search walks the whole table once
    localparam int unsigned DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 16;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    typedef logic [FRAME_BITS-1:0] frame_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [FRAME_BITS:0]    cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata   = '0;   // frame_a, frame_b, replace_frame
    logic [FIT_CMD_W-1:0]   s_tuser   = '0;   // cmd
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_W-1:0]         m_tdata;          // status, hit_first, hit_last, hit_replace
    logic                   m_tuser;          // hit

    // checker outputs
    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_seen;
    int unsigned hits_seen;

    // stimulus bookkeeping
    bit                  steady = 1'b0;   // suppress idling on both sides
    logic [FRAME_BITS:0] frame_limit = '0;
    frame_t              recent_starts [$];
    int unsigned         commands_sent;
    int unsigned         settings_written;
    int unsigned         cycle_count;

    frame_interval_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRAME_BITS    (FRAME_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    fit_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRAME_BITS    (FRAME_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .hits_seen    (hits_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Stall the result side about 20 percent of the time, except in a steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Hard stop: a hung handshake or a lost result ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("tb: failure");
        $finish;
    end

    // Present one command beat and hold it until accepted. Gaps go in front of
    // the beat, so valid never drops while a beat waits.
    task automatic send_command(input logic [FIT_CMD_W-1:0] cmd, input frame_t a,
                                input frame_t b, input frame_t r);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {r, b, a};
        do @(posedge aclk); while (!s_tready);
        commands_sent++;
        // remember add starts so deletes and finds can aim at stored ranges
        if (cmd == FIT_CMD_ADD) begin
            recent_starts = {recent_starts, a};
            if (recent_starts.size() > 128)
                void'(recent_starts.pop_front());
        end
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic wait_idle(input int unsigned settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // Write frame_count only with the table quiet.
    task automatic write_frame_count(input logic [FRAME_BITS:0] value);
        wait_idle(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        frame_limit = value;
        settings_written++;
    endtask

    // Frame mostly below frame_count, sometimes a little above it.
    function automatic frame_t pick_frame();
        logic [FRAME_BITS+1:0] reach;
        reach = {1'b0, frame_limit} + {5'd0, frame_limit[FRAME_BITS:4]}
              + (FRAME_BITS+2)'(1);
        if (reach > {1'b0, FULL_SPAN})
            reach = {1'b0, FULL_SPAN};
        return frame_t'($urandom_range(0, reach - 1));
    endfunction

    task automatic random_command();
        int unsigned           pick;
        int unsigned           shape;
        int unsigned           len;
        logic [FRAME_BITS+1:0] end_frame;
        frame_t                a;
        frame_t                b;
        frame_t                r;
        frame_t                base;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 99);
        a     = pick_frame();
        b     = frame_t'($urandom);
        r     = frame_t'($urandom);
        base  = recent_starts.size() > 0 ?
                recent_starts[$urandom_range(0, recent_starts.size() - 1)] : a;
        if (pick < 35) begin
            // add: mostly short ranges, some wide ones, a few inverted
            r = pick_frame();
            if (shape < 95) begin
                len = shape < 80 ? $urandom_range(0, 15) :
                                   $urandom_range(0, frame_limit / 4 + 1);
                end_frame = a + len;
                b = end_frame > FRAME_MAX ? FRAME_MAX : end_frame[FRAME_BITS-1:0];
            end else begin
                b = a - frame_t'($urandom_range(1, 16));
            end
            send_command(FIT_CMD_ADD, a, b, r);
        end else if (pick < 60) begin
            send_command(FIT_CMD_DEL, shape < 70 ? base : a, b, r);
        end else if (pick < 95) begin
            send_command(FIT_CMD_FIND, shape < 60 ? base + frame_t'($urandom_range(0, 7)) : a,
                         b, r);
        end else begin
            send_command(CMD_UNKNOWN, frame_t'($urandom), b, r);
        end
    endtask

    // Random traffic under one frame_count; hold both sides busy for the
    // first quiet_items beats.
    task automatic run_phase(input logic [FRAME_BITS:0] limit, input int unsigned items,
                             input int unsigned quiet_items);
        write_frame_count(limit);
        for (int i = 0; i < items; i++) begin
            steady <= (i < quiet_items);
            random_command();
        end
        steady <= 1'b0;
    endtask

    // Pack the table past its capacity with disjoint ranges at random offsets.
    task automatic fill_table();
        int unsigned step;
        frame_t      a;
        step = frame_limit / 80;
        for (int i = 0; i < TABLE_ENTRIES + 6; i++) begin
            a = frame_t'(i * step + $urandom_range(0, step / 2));
            send_command(FIT_CMD_ADD, a, a + frame_t'($urandom_range(0, step / 4)),
                         frame_t'($urandom_range(0, frame_limit - 1)));
        end
        // [40, 50] is still stored: overlap is checked ahead of the full condition
        send_command(FIT_CMD_ADD, 40, 45, 0);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // frame_count is still 0 out of reset: every add is out of range
        send_command(FIT_CMD_ADD, 0, 0, 0);

        write_frame_count(FULL_SPAN);
        send_command(FIT_CMD_ADD, 10, 20, 5);
        send_command(FIT_CMD_FIND, 3, 0, 0);                  // below every range
        send_command(FIT_CMD_ADD, 0, 0, 0);
        send_command(FIT_CMD_ADD, FRAME_MAX, FRAME_MAX, FRAME_MAX);
        send_command(FIT_CMD_ADD, 40, 50, 7);
        send_command(FIT_CMD_ADD, 15, 30, 1);                 // first inside a range
        send_command(FIT_CMD_ADD, 5, 12, 1);                  // last inside a range
        send_command(FIT_CMD_ADD, 1, 100, 2);                 // encloses two ranges
        send_command(FIT_CMD_ADD, 30, 25, 0);                 // inverted
        send_command(FIT_CMD_FIND, 0, FRAME_MAX, FRAME_MAX);
        send_command(FIT_CMD_FIND, FRAME_MAX, 0, 0);
        send_command(FIT_CMD_FIND, 45, 0, 0);
        send_command(FIT_CMD_FIND, 35, 0, 0);
        send_command(CMD_UNKNOWN, FRAME_MAX, FRAME_MAX, FRAME_MAX);
        send_command(FIT_CMD_DEL, 15, 0, 0);                  // not a start
        send_command(FIT_CMD_DEL, 10, 0, 0);
        send_command(FIT_CMD_DEL, 10, 0, 0);                  // already gone
        send_command(FIT_CMD_FIND, 15, 0, 0);

        // lower frame_count below stored ranges; check each add bound
        write_frame_count(25'd100);
        send_command(FIT_CMD_ADD, 60, 70, 100);
        send_command(FIT_CMD_ADD, 60, 100, 0);
        send_command(FIT_CMD_ADD, 100, 100, 0);
        send_command(FIT_CMD_FIND, FRAME_MAX, 0, 0);
        send_command(FIT_CMD_ADD, 99, 99, 99);

        write_frame_count(25'd16777215);
        fill_table();

        run_phase(25'd300, 250, 0);
        run_phase(FULL_SPAN, 250, 200);
        run_phase(25'd4096, 300, 0);
        run_phase(25'($urandom_range(2, FULL_SPAN)), 250, 0);
        run_phase(25'd700, 250, 0);
        run_phase(25'd1, 60, 0);

        wait_idle(DRAIN_CYCLES);

        $display("covered %0d commands over %0d frame_count settings, including 0, 1 and 2^24",
                 commands_sent, settings_written);
        $display("%0d results checked, %0d of them reported a stored range",
                 results_seen, hits_seen);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
